/* src/pnsd_pkg.sv */
package pnsd_pkg;

   localparam int MAX_SPHERES = 1024;
   localparam int COORD_BITS = 24;
   localparam int DIAM_BITS = 20;
   localparam int INDEX_BITS = 10;
   localparam int COUNT_BITS = 11;
   localparam int ADDR_BITS = $clog2(MAX_SPHERES);
   localparam int SCAN_BITS = ADDR_BITS + 1;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 24;
   localparam int DIST_BITS = 25;
   localparam int SQ_BITS = 2 * COORD_BITS;
   localparam int SUM_BITS = SQ_BITS + 2;
   localparam int RAD_BITS = SUM_BITS + 2;
   localparam int ROOT_BITS = RAD_BITS / 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOX_X = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOX_Y = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOX_Z = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COUNT = 3'd3;

   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [COORD_BITS-1:0] BOX_RESET = 24'd40960;
   localparam logic signed [DIST_BITS-1:0] SAT_HI = 25'sd16777215;

   typedef struct packed {
      logic                  kind;
      logic [INDEX_BITS-1:0] entry_index;
      logic [COORD_BITS-1:0] pos_x;
      logic [COORD_BITS-1:0] pos_y;
      logic [COORD_BITS-1:0] pos_z;
      logic [DIAM_BITS-1:0]  diameter;
   } req_type;

   typedef struct packed {
      logic signed [DIST_BITS-1:0] min_distance;
      logic                        valid_res;
   } rsp_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] z;
      logic [DIAM_BITS-1:0]  diameter;
   } sphere_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

/* src/pnsd_table.sv */
module pnsd_table
   import pnsd_pkg::*;
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  sphere_type           wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output sphere_type           rd_data
);

   sphere_type mem_ff [MAX_SPHERES];
   sphere_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/pnsd_wrap.sv */
module pnsd_wrap
   import pnsd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COORD_BITS-1:0] mag,
   input  logic [COORD_BITS-1:0] len,
   output unit_status_type       status,
   output logic [COORD_BITS-1:0] result
);

   typedef enum logic [1:0] {W_IDLE, W_RUN, W_FOLD} wrap_state_type;

   localparam int CNT_BITS = $clog2(COORD_BITS);

   wrap_state_type        state_ff;
   logic [COORD_BITS-1:0] mag_ff;
   logic [COORD_BITS-1:0] len_ff;
   logic [COORD_BITS-1:0] rem_ff;
   logic [COORD_BITS-1:0] rem_in;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [COORD_BITS-1:0] result_ff;
   logic                  done_ff;
   logic [COORD_BITS:0]   shifted;

   always_comb begin
      shifted = {rem_ff, mag_ff[cnt_ff]};
      if (shifted >= {1'b0, len_ff}) begin
         rem_in = COORD_BITS'(shifted - {1'b0, len_ff});
      end else begin
         rem_in = shifted[COORD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            W_IDLE: begin
               if (start) begin
                  mag_ff   <= mag;
                  len_ff   <= len;
                  rem_ff   <= '0;
                  cnt_ff   <= CNT_BITS'(COORD_BITS - 1);
                  state_ff <= W_RUN;
               end
            end
            W_RUN: begin
               rem_ff <= rem_in;
               if (cnt_ff == '0) begin
                  state_ff <= W_FOLD;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            W_FOLD: begin
               if (len_ff == '0) begin
                  result_ff <= mag_ff;
               end else if ({1'b0, rem_ff, 1'b0} >= {2'b00, len_ff}) begin
                  result_ff <= len_ff - rem_ff;
               end else begin
                  result_ff <= rem_ff;
               end
               done_ff  <= 1'b1;
               state_ff <= W_IDLE;
            end
            default: state_ff <= W_IDLE;
         endcase
      end
   end

   assign status.busy = (state_ff != W_IDLE);
   assign status.done = done_ff;
   assign result      = result_ff;

endmodule

/* src/pnsd_isqrt.sv */
module pnsd_isqrt
   import pnsd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [SUM_BITS-1:0]  sum,
   output unit_status_type      status,
   output logic [ROOT_BITS-1:0] root
);

   logic [RAD_BITS-1:0] v_ff;
   logic [RAD_BITS-1:0] res_ff;
   logic [RAD_BITS-1:0] bit_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [RAD_BITS-1:0] trial;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff) begin
            if (start) begin
               v_ff    <= {sum, 2'b00};
               res_ff  <= '0;
               bit_ff  <= RAD_BITS'(1) << (RAD_BITS - 2);
               busy_ff <= 1'b1;
            end
         end else begin
            if (v_ff >= trial) begin
               v_ff   <= v_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            if (bit_ff[0]) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = res_ff[ROOT_BITS-1:0];

endmodule

/* src/periodic_nearest_surface_distance_top.sv */
// Nearest sphere-surface distance in a periodic box.
// Request channel (req_valid/req_ready/req_data): kind 0 loads one sphere
// (centre, diameter) into the table slot entry_index;
// kind 1 queries a point and produces one response on rsp_valid/rsp_ready.
// CSR port (csr_we/csr_index/csr_wdata): box lengths per axis and the number
// of table entries a query scans; write only while no query is in flight.
// A query scans entries 0..n-1 sequentially with one shared remainder unit,
// one multiplier and one bit-serial square-root unit. Per sphere: a table
// read and latch; per axis a remainder-unit start, the remainder steps and
// fold, a square and an accumulate; then the square root and a compare.
// An empty scan goes straight to the response without reading the table.
// req_ready is high only while the sequencer is idle; a finished response
// sits in the output register, and the next request is accepted while it
// waits. A new result waits until the receiver has taken the previous one.
// Reset (synchronous, active high) restores the register defaults and drops
// any pending response; table contents are kept and are undefined until
// loaded.
module periodic_nearest_surface_distance_top
   import pnsd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_LATCH, S_AXIS, S_WRAP, S_SQUARE, S_ACCUM, S_SQRT,
      S_COMPARE, S_DONE
   } state_type;

   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int BEST_BITS = ROOT_BITS;

   state_type                     state_ff;
   logic [COORD_BITS-1:0]         box_x_ff, box_y_ff, box_z_ff;
   logic [COUNT_BITS-1:0]         count_ff;
   logic [COORD_BITS-1:0]         pt_x_ff, pt_y_ff, pt_z_ff;
   logic [SCAN_BITS-1:0]          n_ff;
   logic [SCAN_BITS-1:0]          idx_ff;
   logic [1:0]                    axis_ff;
   logic [SQ_BITS-1:0]            sq_ff;
   logic [SUM_BITS-1:0]           sum_ff;
   logic signed [BEST_BITS-1:0]   best_ff;
   logic signed [BEST_BITS-1:0]   dist_ff;
   logic                          any_ff;
   logic                          rsp_valid_ff;
   rsp_type                       rsp_data_ff;

   logic                          req_fire;
   logic                          wr_en;
   sphere_type                    wr_data;
   sphere_type                    sphere;
   logic                          rd_en;
   logic [COORD_BITS-1:0]         p_sel, s_sel, len_sel;
   logic signed [DIFF_BITS-1:0]   diff;
   logic [COORD_BITS-1:0]         mag;
   logic                          wrap_start;
   unit_status_type               wrap_status;
   logic [COORD_BITS-1:0]         wrapped;
   logic                          sqrt_start;
   unit_status_type               sqrt_status;
   logic [ROOT_BITS-1:0]          root;
   logic signed [ROOT_BITS:0]     twice;
   logic [SCAN_BITS-1:0]          n_in;
   logic signed [DIST_BITS-1:0]   best_sat;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign wr_en     = req_fire && (req_data.kind == KIND_LOAD)
                      && ({1'b0, req_data.entry_index} < (INDEX_BITS + 1)'(MAX_SPHERES));
   assign wr_data   = '{x: req_data.pos_x, y: req_data.pos_y, z: req_data.pos_z,
                        diameter: req_data.diameter};
   assign rd_en     = (state_ff == S_READ);

   pnsd_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_BITS'(req_data.entry_index)),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff[ADDR_BITS-1:0]),
      .rd_data (sphere)
   );

   always_comb begin
      unique case (axis_ff)
         2'd0: begin
            p_sel = pt_x_ff; s_sel = sphere.x; len_sel = box_x_ff;
         end
         2'd1: begin
            p_sel = pt_y_ff; s_sel = sphere.y; len_sel = box_y_ff;
         end
         default: begin
            p_sel = pt_z_ff; s_sel = sphere.z; len_sel = box_z_ff;
         end
      endcase
      diff = $signed({1'b0, p_sel}) - $signed({1'b0, s_sel});
      mag  = diff[DIFF_BITS-1] ? COORD_BITS'(-diff) : diff[COORD_BITS-1:0];
   end

   assign wrap_start = (state_ff == S_AXIS);
   assign sqrt_start = (state_ff == S_ACCUM) && (axis_ff == 2'd2);

   pnsd_wrap u_wrap (
      .clock  (clock),
      .reset  (reset),
      .start  (wrap_start),
      .mag    (mag),
      .len    (len_sel),
      .status (wrap_status),
      .result (wrapped)
   );

   pnsd_isqrt u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (sqrt_start),
      .sum    (sum_ff + SUM_BITS'(sq_ff)),
      .status (sqrt_status),
      .root   (root)
   );

   assign twice = $signed({1'b0, root}) - $signed((ROOT_BITS + 1)'(sphere.diameter));

   always_comb begin
      if ({1'b0, count_ff} > (COUNT_BITS + 1)'(MAX_SPHERES)) begin
         n_in = SCAN_BITS'(MAX_SPHERES);
      end else begin
         n_in = SCAN_BITS'(count_ff);
      end
      if (best_ff > BEST_BITS'(SAT_HI)) begin
         best_sat = SAT_HI;
      end else begin
         best_sat = DIST_BITS'(best_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff <= BOX_RESET;
         box_y_ff <= BOX_RESET;
         box_z_ff <= BOX_RESET;
         count_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BOX_X: box_x_ff <= csr_wdata[COORD_BITS-1:0];
            CSR_BOX_Y: box_y_ff <= csr_wdata[COORD_BITS-1:0];
            CSR_BOX_Z: box_z_ff <= csr_wdata[COORD_BITS-1:0];
            CSR_COUNT: count_ff <= csr_wdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         any_ff       <= 1'b0;
      end else begin
         if ((state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire && (req_data.kind == KIND_QUERY)) begin
                  pt_x_ff <= req_data.pos_x;
                  pt_y_ff <= req_data.pos_y;
                  pt_z_ff <= req_data.pos_z;
                  n_ff    <= n_in;
                  idx_ff  <= '0;
                  any_ff  <= 1'b0;
                  best_ff <= '0;
                  state_ff <= (n_in == '0) ? S_DONE : S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_LATCH;
            end
            S_LATCH: begin
               axis_ff  <= 2'd0;
               sum_ff   <= '0;
               state_ff <= S_AXIS;
            end
            S_AXIS: begin
               state_ff <= S_WRAP;
            end
            S_WRAP: begin
               if (wrap_status.done) begin
                  state_ff <= S_SQUARE;
               end
            end
            S_SQUARE: begin
               sq_ff    <= wrapped * wrapped;
               state_ff <= S_ACCUM;
            end
            S_ACCUM: begin
               sum_ff <= sum_ff + SUM_BITS'(sq_ff);
               if (axis_ff == 2'd2) begin
                  state_ff <= S_SQRT;
               end else begin
                  axis_ff  <= axis_ff + 2'd1;
                  state_ff <= S_AXIS;
               end
            end
            S_SQRT: begin
               if (sqrt_status.done) begin
                  dist_ff  <= twice[ROOT_BITS:1];
                  state_ff <= S_COMPARE;
               end
            end
            S_COMPARE: begin
               if (!any_ff || (dist_ff < best_ff)) begin
                  best_ff <= dist_ff;
               end
               any_ff <= 1'b1;
               idx_ff <= idx_ff + 1'b1;
               state_ff <= (idx_ff + 1'b1 == n_ff) ? S_DONE : S_READ;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_data_ff.valid_res    <= any_ff;
                  rsp_data_ff.min_distance <= any_ff ? best_sat : '0;
                  state_ff                 <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/pnsd_checker.sv */
module pnsd_checker
   import pnsd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.valid_res |-> rsp_data.min_distance == '0)
      else $error("empty scan with nonzero distance");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.kind == KIND_QUERY |=> !req_ready)
      else $error("ready after query accept");

   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.kind == KIND_LOAD |=> req_ready)
      else $error("load stalled request channel");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("state not cleared by reset");

endmodule

bind periodic_nearest_surface_distance_top pnsd_checker u_pnsd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
